// ===== hw/rtl/pbld_pkg.sv =====
// Shared constants, codes and types of the page buffer LRU directory.
// Has no dependencies; the interfaces, the scan unit and the top level import it.
package pbld_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam int OP_W   = 3;
    localparam int FILE_W = 8;
    localparam int PAGE_W = 24;
    localparam int SLOT_W = 6;

    localparam logic [OP_W-1:0] OP_FIND       = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD        = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OP_W-1:0] OP_FORCE      = 3'd3;
    localparam logic [OP_W-1:0] OP_MARK_DIRTY = 3'd4;

    localparam logic [1:0] UPD_NONE   = 2'd0;
    localparam logic [1:0] UPD_TOUCH  = 2'd1;
    localparam logic [1:0] UPD_REMOVE = 2'd2;
    localparam logic [1:0] UPD_INSERT = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic       tgt_valid;
        logic       tgt_dirty;
        logic       tgt_keep_rank;
    } upd_ctl_t;

endpackage

// ===== hw/rtl/pbld_req_if.sv =====
// Request channel of the page buffer LRU directory: valid, ready and one request item.
// Depends on pbld_pkg for the field widths.
interface pbld_req_if;
    import pbld_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [FILE_W-1:0] file_number;
    logic [PAGE_W-1:0] page_index;

    modport source (output valid, output opcode, output file_number, output page_index,
                    input ready);
    modport sink (input valid, input opcode, input file_number, input page_index,
                  output ready);
endinterface

// ===== hw/rtl/pbld_rsp_if.sv =====
// Response channel of the page buffer LRU directory: valid, ready and one result item.
// Depends on pbld_pkg for the field widths.
interface pbld_rsp_if;
    import pbld_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              write_back;
    logic              replaced;
    logic [FILE_W-1:0] victim_file;
    logic [PAGE_W-1:0] victim_page;

    modport source (output valid, output hit, output slot, output write_back,
                    output replaced, output victim_file, output victim_page,
                    input ready);
    modport sink (input valid, input hit, input slot, input write_back,
                  input replaced, input victim_file, input victim_page,
                  output ready);
endinterface

// ===== hw/rtl/pbld_dir_mem.sv =====
// Slot directory memory: one write port and one read port with registered read data.
// Generic; no package dependencies.
module pbld_dir_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== hw/rtl/pbld_free_stack.sv =====
// LIFO stack of free slot numbers with a low-water mark standing in for the reset fill.
// Depends on nothing but its parameter; the top is always presented registered.
module pbld_free_stack #(
    parameter int SLOTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop,
    input  logic                       push,
    input  logic [$clog2(SLOTS)-1:0]   push_slot,
    output logic [$clog2(SLOTS+1)-1:0] count,
    output logic [$clog2(SLOTS)-1:0]   top
);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [IDX_W-1:0] mem [SLOTS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] low_reg;
    logic [CNT_W-1:0] low_next;
    logic [CNT_W-1:0] pos;
    logic [IDX_W-1:0] top_mem_reg;
    logic [IDX_W-1:0] pos_reg;
    logic             below_reg;

    // Entries below the lowest fill level ever reached read back as their own index.
    assign pos = (count_reg == '0) ? '0 : count_reg - CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        low_next   = low_reg;
        if (pop && count_reg != '0)
        begin
            count_next = count_reg - CNT_W'(1);
            if (pos < low_reg)
            begin
                low_next = pos;
            end
        end
        else if (push && count_reg < CNT_W'(SLOTS))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(SLOTS);
            low_reg   <= CNT_W'(SLOTS);
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop && count_reg < CNT_W'(SLOTS))
        begin
            mem[count_reg[IDX_W-1:0]] <= push_slot;
        end
        top_mem_reg <= mem[pos[IDX_W-1:0]];
        pos_reg     <= pos[IDX_W-1:0];
        below_reg   <= (pos < low_reg);
    end

    assign count = count_reg;
    assign top   = below_reg ? pos_reg : top_mem_reg;
endmodule

// ===== hw/rtl/pbld_scan_unit.sv =====
// Shared per-entry unit: key match, rank compare and the updated entry for one slot.
// Depends on pbld_pkg for field widths, update modes and the control struct.
module pbld_scan_unit #(
    parameter int RANK_W = 6
) (
    input  logic                        ent_valid,
    input  logic                        ent_dirty,
    input  logic [RANK_W-1:0]           ent_rank,
    input  logic [pbld_pkg::FILE_W-1:0] ent_file,
    input  logic [pbld_pkg::PAGE_W-1:0] ent_page,
    input  logic [pbld_pkg::FILE_W-1:0] key_file,
    input  logic [pbld_pkg::PAGE_W-1:0] key_page,
    input  logic [RANK_W-1:0]           cmp_rank,
    input  logic                        is_target,
    input  pbld_pkg::upd_ctl_t          ctl,
    output logic                        match,
    output logic                        rank_gt,
    output logic                        nxt_valid,
    output logic                        nxt_dirty,
    output logic [RANK_W-1:0]           nxt_rank,
    output logic [pbld_pkg::FILE_W-1:0] nxt_file,
    output logic [pbld_pkg::PAGE_W-1:0] nxt_page
);
    import pbld_pkg::*;

    logic rank_lt;

    assign match   = ent_valid && ent_file == key_file && ent_page == key_page;
    assign rank_gt = ent_rank > cmp_rank;
    assign rank_lt = ent_rank < cmp_rank;

    always_comb
    begin
        nxt_valid = ent_valid;
        nxt_dirty = ent_dirty;
        nxt_rank  = ent_rank;
        nxt_file  = ent_file;
        nxt_page  = ent_page;
        if (is_target)
        begin
            nxt_valid = ctl.tgt_valid;
            nxt_dirty = ctl.tgt_dirty;
            nxt_rank  = ctl.tgt_keep_rank ? ent_rank : '0;
            nxt_file  = key_file;
            nxt_page  = key_page;
        end
        else if (ent_valid)
        begin
            unique case (ctl.mode)
                UPD_TOUCH:
                begin
                    if (rank_lt)
                    begin
                        nxt_rank = ent_rank + RANK_W'(1);
                    end
                end
                UPD_REMOVE:
                begin
                    if (rank_gt)
                    begin
                        nxt_rank = ent_rank - RANK_W'(1);
                    end
                end
                UPD_INSERT:
                begin
                    nxt_rank = ent_rank + RANK_W'(1);
                end
                UPD_NONE:
                begin
                    nxt_rank = ent_rank;
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/page_buffer_lru_directory_top.sv =====
// Top level of the page buffer LRU directory: sequencer, request and result registers.
// Depends on pbld_pkg, pbld_req_if, pbld_rsp_if, pbld_dir_mem, pbld_free_stack and
// pbld_scan_unit.
//
// The req channel takes one request item (opcode, file_number, page_index) and the rsp
// channel returns exactly one result item for it, in order. Both use valid/ready; an item
// moves at a rising edge with valid and ready high.
// A request walks the slot directory twice through one shared match and rank-compare
// unit: a lookup pass that finds the page and the least recent resident slot, then an
// update pass that rewrites every slot's rank and the target slot. Each pass reads one
// slot per cycle from the directory memory; requests that change nothing skip the update
// pass. The next request is accepted only once the result has moved to the output
// register, and req.ready is high only while no request is in work.
// The result sits in an output register; the next request is accepted while it waits,
// but a finished request holds until the register is free when rsp.ready stays low.
// After reset the block clears the valid and dirty marks of all slots, one slot per
// cycle, and accepts no request until all slots are cleared.
module page_buffer_lru_directory_top #(
    parameter int SLOTS = pbld_pkg::SLOTS_DEFAULT
) (
    input logic      clk,
    input logic      rst_n,
    pbld_req_if.sink   req,
    pbld_rsp_if.source rsp
);
    import pbld_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int RANK_W = IDX_W;
    localparam int ENT_W  = 2 + RANK_W + FILE_W + PAGE_W;

    localparam logic [2:0] ST_CLR    = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]       state_reg,     state_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic             rd_valid_reg,  rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg,    rd_idx_next;
    logic             out_valid_reg, out_valid_next;

    logic [OP_W-1:0]   op_reg,       op_next;
    logic [FILE_W-1:0] key_file_reg, key_file_next;
    logic [PAGE_W-1:0] key_page_reg, key_page_next;
    logic              found_reg,    found_next;
    logic [IDX_W-1:0]  s_idx_reg,    s_idx_next;
    logic [RANK_W-1:0] s_rank_reg,   s_rank_next;
    logic              s_dirty_reg,  s_dirty_next;
    logic              vfound_reg,   vfound_next;
    logic [IDX_W-1:0]  v_idx_reg,    v_idx_next;
    logic [RANK_W-1:0] best_reg,     best_next;
    logic [FILE_W-1:0] v_file_reg,   v_file_next;
    logic [PAGE_W-1:0] v_page_reg,   v_page_next;
    logic              v_dirty_reg,  v_dirty_next;
    upd_ctl_t          ctl_reg,      ctl_next;
    logic [IDX_W-1:0]  tgt_reg,      tgt_next;
    logic [RANK_W-1:0] ref_rank_reg, ref_rank_next;
    logic              res_hit_reg,  res_hit_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_wb_reg,   res_wb_next;
    logic              res_rep_reg,  res_rep_next;
    logic [FILE_W-1:0] res_vf_reg,   res_vf_next;
    logic [PAGE_W-1:0] res_vp_reg,   res_vp_next;
    logic              out_hit_reg,  out_hit_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_wb_reg,   out_wb_next;
    logic              out_rep_reg,  out_rep_next;
    logic [FILE_W-1:0] out_vf_reg,   out_vf_next;
    logic [PAGE_W-1:0] out_vp_reg,   out_vp_next;

    logic             rd_issue;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             last_entry;

    logic              ent_valid;
    logic              ent_dirty;
    logic [RANK_W-1:0] ent_rank;
    logic [FILE_W-1:0] ent_file;
    logic [PAGE_W-1:0] ent_page;
    logic [RANK_W-1:0] cmp_rank;
    logic              is_target;
    logic              match;
    logic              rank_gt;
    logic              nxt_valid;
    logic              nxt_dirty;
    logic [RANK_W-1:0] nxt_rank;
    logic [FILE_W-1:0] nxt_file;
    logic [PAGE_W-1:0] nxt_page;

    logic             fs_pop;
    logic             fs_push;
    logic [CNT_W-1:0] fs_count;
    logic [IDX_W-1:0] fs_top;
    logic             hit_ok;

    pbld_dir_mem #(
        .DEPTH (SLOTS),
        .WIDTH (ENT_W)
    ) u_dir_mem (
        .clk     (clk),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pbld_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (fs_pop),
        .push      (fs_push),
        .push_slot (s_idx_reg),
        .count     (fs_count),
        .top       (fs_top)
    );

    assign ent_page  = rd_data[PAGE_W-1:0];
    assign ent_file  = rd_data[PAGE_W +: FILE_W];
    assign ent_rank  = rd_data[PAGE_W + FILE_W +: RANK_W];
    assign ent_dirty = rd_data[ENT_W-2];
    assign ent_valid = rd_data[ENT_W-1];
    assign is_target = (rd_idx_reg == tgt_reg);
    assign cmp_rank  = (state_reg == ST_UPD) ? ref_rank_reg : best_reg;

    pbld_scan_unit #(
        .RANK_W (RANK_W)
    ) u_scan_unit (
        .ent_valid (ent_valid),
        .ent_dirty (ent_dirty),
        .ent_rank  (ent_rank),
        .ent_file  (ent_file),
        .ent_page  (ent_page),
        .key_file  (key_file_reg),
        .key_page  (key_page_reg),
        .cmp_rank  (cmp_rank),
        .is_target (is_target),
        .ctl       (ctl_reg),
        .match     (match),
        .rank_gt   (rank_gt),
        .nxt_valid (nxt_valid),
        .nxt_dirty (nxt_dirty),
        .nxt_rank  (nxt_rank),
        .nxt_file  (nxt_file),
        .nxt_page  (nxt_page)
    );

    assign rd_addr    = cnt_reg[IDX_W-1:0];
    assign last_entry = rd_valid_reg && rd_idx_reg == IDX_W'(SLOTS - 1);
    assign hit_ok     = found_reg && op_reg <= OP_MARK_DIRTY;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        op_next        = op_reg;
        key_file_next  = key_file_reg;
        key_page_next  = key_page_reg;
        found_next     = found_reg;
        s_idx_next     = s_idx_reg;
        s_rank_next    = s_rank_reg;
        s_dirty_next   = s_dirty_reg;
        vfound_next    = vfound_reg;
        v_idx_next     = v_idx_reg;
        best_next      = best_reg;
        v_file_next    = v_file_reg;
        v_page_next    = v_page_reg;
        v_dirty_next   = v_dirty_reg;
        ctl_next       = ctl_reg;
        tgt_next       = tgt_reg;
        ref_rank_next  = ref_rank_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_wb_next    = res_wb_reg;
        res_rep_next   = res_rep_reg;
        res_vf_next    = res_vf_reg;
        res_vp_next    = res_vp_reg;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        out_wb_next    = out_wb_reg;
        out_rep_next   = out_rep_reg;
        out_vf_next    = out_vf_reg;
        out_vp_next    = out_vp_reg;
        req.ready      = 1'b0;
        rd_issue       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = rd_idx_reg;
        wr_data        = {nxt_valid, nxt_dirty, nxt_rank, nxt_file, nxt_page};
        fs_pop         = 1'b0;
        fs_push        = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[IDX_W-1:0];
                wr_data = '0;
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next       = req.opcode;
                    key_file_next = req.file_number;
                    key_page_next = req.page_index;
                    found_next    = 1'b0;
                    vfound_next   = 1'b0;
                    best_next     = '0;
                    cnt_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_issue = cnt_reg < CNT_W'(SLOTS);
                if (rd_issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    if (match && !found_reg)
                    begin
                        found_next   = 1'b1;
                        s_idx_next   = rd_idx_reg;
                        s_rank_next  = ent_rank;
                        s_dirty_next = ent_dirty;
                    end
                    if (ent_valid && (!vfound_reg || rank_gt))
                    begin
                        vfound_next  = 1'b1;
                        v_idx_next   = rd_idx_reg;
                        best_next    = ent_rank;
                        v_file_next  = ent_file;
                        v_page_next  = ent_page;
                        v_dirty_next = ent_dirty;
                    end
                    if (last_entry)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                res_hit_next           = 1'b0;
                res_slot_next          = '0;
                res_wb_next            = 1'b0;
                res_rep_next           = 1'b0;
                res_vf_next            = '0;
                res_vp_next            = '0;
                ctl_next.mode          = UPD_NONE;
                ctl_next.tgt_valid     = 1'b1;
                ctl_next.tgt_dirty     = 1'b0;
                ctl_next.tgt_keep_rank = 1'b0;
                tgt_next               = s_idx_reg;
                ref_rank_next          = s_rank_reg;
                cnt_next               = '0;
                state_next             = ST_UPD;
                if (hit_ok)
                begin
                    res_hit_next = 1'b1;
                    priority if (op_reg == OP_FIND || op_reg == OP_ADD)
                    begin
                        ctl_next.mode      = UPD_TOUCH;
                        ctl_next.tgt_dirty = s_dirty_reg;
                        res_slot_next      = SLOT_W'(s_idx_reg);
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        ctl_next.mode      = UPD_REMOVE;
                        ctl_next.tgt_valid = 1'b0;
                        res_wb_next        = s_dirty_reg;
                        res_vf_next        = s_dirty_reg ? key_file_reg : '0;
                        res_vp_next        = s_dirty_reg ? key_page_reg : '0;
                        fs_push            = 1'b1;
                    end
                    else if (op_reg == OP_FORCE)
                    begin
                        ctl_next.tgt_keep_rank = 1'b1;
                        res_wb_next            = s_dirty_reg;
                        res_vf_next            = s_dirty_reg ? key_file_reg : '0;
                        res_vp_next            = s_dirty_reg ? key_page_reg : '0;
                        res_slot_next          = SLOT_W'(s_idx_reg);
                    end
                    else
                    begin
                        ctl_next.tgt_keep_rank = 1'b1;
                        ctl_next.tgt_dirty     = 1'b1;
                        res_slot_next          = SLOT_W'(s_idx_reg);
                    end
                end
                else if (op_reg == OP_ADD)
                begin
                    if (fs_count != '0)
                    begin
                        fs_pop        = 1'b1;
                        ctl_next.mode = UPD_INSERT;
                        tgt_next      = fs_top;
                        res_slot_next = SLOT_W'(fs_top);
                    end
                    else if (vfound_reg)
                    begin
                        ctl_next.mode = UPD_TOUCH;
                        tgt_next      = v_idx_reg;
                        ref_rank_next = best_reg;
                        res_slot_next = SLOT_W'(v_idx_reg);
                        res_rep_next  = 1'b1;
                        res_wb_next   = v_dirty_reg;
                        res_vf_next   = v_file_reg;
                        res_vp_next   = v_page_reg;
                    end
                    else
                    begin
                        ctl_next.mode = UPD_TOUCH;
                        tgt_next      = '0;
                        ref_rank_next = '0;
                        res_slot_next = '0;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UPD:
            begin
                rd_issue = cnt_reg < CNT_W'(SLOTS);
                if (rd_issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    wr_en = 1'b1;
                    if (last_entry)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_slot_next  = res_slot_reg;
                    out_wb_next    = res_wb_reg;
                    out_rep_next   = res_rep_reg;
                    out_vf_next    = res_vf_reg;
                    out_vp_next    = res_vp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_valid_next = rd_issue;
        rd_idx_next   = rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        op_reg       <= op_next;
        key_file_reg <= key_file_next;
        key_page_reg <= key_page_next;
        found_reg    <= found_next;
        s_idx_reg    <= s_idx_next;
        s_rank_reg   <= s_rank_next;
        s_dirty_reg  <= s_dirty_next;
        vfound_reg   <= vfound_next;
        v_idx_reg    <= v_idx_next;
        best_reg     <= best_next;
        v_file_reg   <= v_file_next;
        v_page_reg   <= v_page_next;
        v_dirty_reg  <= v_dirty_next;
        ctl_reg      <= ctl_next;
        tgt_reg      <= tgt_next;
        ref_rank_reg <= ref_rank_next;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        res_wb_reg   <= res_wb_next;
        res_rep_reg  <= res_rep_next;
        res_vf_reg   <= res_vf_next;
        res_vp_reg   <= res_vp_next;
        out_hit_reg  <= out_hit_next;
        out_slot_reg <= out_slot_next;
        out_wb_reg   <= out_wb_next;
        out_rep_reg  <= out_rep_next;
        out_vf_reg   <= out_vf_next;
        out_vp_reg   <= out_vp_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.write_back  = out_wb_reg;
    assign rsp.replaced    = out_rep_reg;
    assign rsp.victim_file = out_vf_reg;
    assign rsp.victim_page = out_vp_reg;

`ifndef ASSERT_OFF
    a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fs_count <= CNT_W'(SLOTS))
        else $error("free slot count exceeds the pool size");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("accepted request did not start the lookup pass");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fs_pop |-> (fs_count != '0 && !fs_push))
        else $error("free stack popped while empty or together with a push");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside the completion state");

    a_hit_not_replaced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_rep_reg))
        else $error("a hit reported an eviction");
`endif
endmodule
